[design/ciseu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ciseu_pkg
// Shared opcodes, action codes and the control record of the execute unit.
// ----------------------------------------------------------------------------
package ciseu_pkg;

  localparam int DefaultDataWidth = 64;
  localparam int XW = 64;  // fixed port width of address and value fields

  // opcode groups (opcode bits 6..4)
  localparam logic [2:0] GRP_ALU = 3'h0;
  localparam logic [2:0] GRP_CTL = 3'h1;
  localparam logic [2:0] GRP_SYS = 3'h2;

  // group 0
  localparam logic [3:0] ALU_ADD  = 4'h0;
  localparam logic [3:0] ALU_MUL  = 4'h1;
  localparam logic [3:0] ALU_SUB  = 4'h2;
  localparam logic [3:0] ALU_DIV  = 4'h3;
  localparam logic [3:0] ALU_OR   = 4'h4;
  localparam logic [3:0] ALU_XOR  = 4'h5;
  localparam logic [3:0] ALU_NOR  = 4'h6;
  localparam logic [3:0] ALU_AND  = 4'h7;
  localparam logic [3:0] ALU_NAND = 4'h8;
  localparam logic [3:0] ALU_NOT  = 4'h9;
  localparam logic [3:0] ALU_CMP  = 4'ha;
  localparam logic [3:0] ALU_INC  = 4'hb;
  localparam logic [3:0] ALU_DEC  = 4'hc;
  localparam logic [3:0] ALU_SHL  = 4'hd;
  localparam logic [3:0] ALU_SHR  = 4'he;

  // group 1
  localparam logic [3:0] CTL_RET  = 4'h0;
  localparam logic [3:0] CTL_CALL = 4'h1;
  localparam logic [3:0] CTL_JMP  = 4'h2;
  localparam logic [3:0] CTL_JC   = 4'h3;
  localparam logic [3:0] CTL_JNC  = 4'h4;
  localparam logic [3:0] CTL_JZ   = 4'h5;
  localparam logic [3:0] CTL_JNZ  = 4'h6;
  localparam logic [3:0] CTL_JL   = 4'h7;
  localparam logic [3:0] CTL_JLE  = 4'h8;
  localparam logic [3:0] CTL_JNL  = 4'h9;
  localparam logic [3:0] CTL_JNLE = 4'ha;
  localparam logic [3:0] CTL_JG   = 4'hb;
  localparam logic [3:0] CTL_JGE  = 4'hc;
  localparam logic [3:0] CTL_JNG  = 4'hd;
  localparam logic [3:0] CTL_JNGE = 4'he;

  // group 2
  localparam logic [3:0] SYS_MOV   = 4'h0;
  localparam logic [3:0] SYS_NOP   = 4'h1;
  localparam logic [3:0] SYS_HLT   = 4'h2;
  localparam logic [3:0] SYS_PUSH  = 4'h3;
  localparam logic [3:0] SYS_POP   = 4'h4;
  localparam logic [3:0] SYS_PUSHA = 4'h5;
  localparam logic [3:0] SYS_POPA  = 4'h6;
  localparam logic [3:0] SYS_INT   = 4'h7;
  localparam logic [3:0] SYS_LIDT  = 4'h8;
  localparam logic [3:0] SYS_IRET  = 4'h9;
  localparam logic [3:0] SYS_SCALL = 4'ha;
  localparam logic [3:0] SYS_SRET  = 4'hb;
  localparam logic [3:0] SYS_EUSER = 4'hc;

  localparam logic [1:0] STK_NONE   = 2'd0;
  localparam logic [1:0] STK_PUSH   = 2'd1;
  localparam logic [1:0] STK_POP    = 2'd2;
  localparam logic [1:0] STK_POP_IP = 2'd3;

  localparam logic [3:0] ACT_NONE  = 4'd0;
  localparam logic [3:0] ACT_HALT  = 4'd1;
  localparam logic [3:0] ACT_INT   = 4'd2;
  localparam logic [3:0] ACT_LIDT  = 4'd3;
  localparam logic [3:0] ACT_IRET  = 4'd4;
  localparam logic [3:0] ACT_LEAVE = 4'd5;
  localparam logic [3:0] ACT_SRET  = 4'd6;
  localparam logic [3:0] ACT_ENTER = 4'd7;
  localparam logic [3:0] ACT_PUSHA = 4'd8;
  localparam logic [3:0] ACT_POPA  = 4'd9;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_INVAL = 3'd1;
  localparam logic [2:0] FLT_DIV0  = 3'd2;
  localparam logic [2:0] FLT_USER  = 3'd3;
  localparam logic [2:0] FLT_SUPV  = 3'd4;

  typedef struct packed {
    logic [XW-1:0] res;
    logic [XW-1:0] sval;
    logic [XW-1:0] next_ip;
    logic          wd;
    logic          wp;
    logic          br;
    logic [1:0]    stk;
    logic [3:0]    sys;
    logic [2:0]    flt;
    logic          is_mul;
    logic          is_div;
  } ctrl_t;

endpackage
`default_nettype wire

[design/custom_isa_execute_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// custom_isa_execute_unit
// Pipelined execute stage: decode, ALU, branch, stack/system action, fault.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction enters when start is high and busy is low. busy is always
//   low, so one instruction can enter every clock cycle.
//   Each instruction gives exactly one result, shown on the result ports for
//   one cycle with result_valid high, in order of entry.
//   The pipeline is one decode/partial-product stage, then
//   DATA_WIDTH stages of the restoring divider, one quotient bit per stage.
//   The multiplier is split into three half-width products in the first
//   stage and summed in the second. Throughput is one instruction per cycle.
//   Every other field rides along with the divider stages.
//   Reset (rst, synchronous) clears all valid bits; instructions in flight
//   are dropped. The receiver cannot stall: results are taken as shown.
// ----------------------------------------------------------------------------
module custom_isa_execute_unit #(
  parameter int DATA_WIDTH = ciseu_pkg::DefaultDataWidth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  opcode,
  input  wire logic [63:0] dest_value,
  input  wire logic [63:0] source_value,
  input  wire logic [3:0]  status_flags,
  input  wire logic [63:0] fallthrough_ip,
  input  wire logic        protected_mode,
  input  wire logic        user_mode,
  output logic             result_valid,
  output logic [63:0]      result_value,
  output logic [63:0]      remainder_value,
  output logic             writes_dest,
  output logic             writes_pair,
  output logic             branch_taken,
  output logic [63:0]      next_ip,
  output logic [1:0]       stack_action,
  output logic [63:0]      stack_value,
  output logic [3:0]       system_action,
  output logic [2:0]       fault_code
);

  localparam int W   = DATA_WIDTH;
  localparam int HW  = W / 2;
  localparam int LW  = W - HW;
  localparam int SW  = $clog2(W);
  localparam int LAT = W + 1;

  assign busy = 1'b0;

  // ---------------- decode ----------------
  logic [W-1:0]     a, b;
  ciseu_pkg::ctrl_t dec;

  assign a = dest_value[W-1:0];
  assign b = source_value[W-1:0];

  always_comb begin
    logic [2:0]   grp;
    logic [3:0]   sel;
    logic [W-1:0] v;
    logic         lt, c, z, take, bad, user_bad;
    logic [2:0]   code;
    grp      = opcode[6:4];
    sel      = opcode[3:0];
    c        = status_flags[0];
    z        = status_flags[1];
    lt       = status_flags[2] ^ status_flags[3];
    user_bad = protected_mode & user_mode;
    v        = '0;
    take     = 1'b0;
    bad      = 1'b0;
    code     = ciseu_pkg::FLT_NONE;
    dec      = '0;
    dec.next_ip = fallthrough_ip;
    case (grp)
      ciseu_pkg::GRP_ALU: begin
        dec.wd = 1'b1;
        unique case (sel)
          ciseu_pkg::ALU_ADD:  v = a + b;
          ciseu_pkg::ALU_MUL:  dec.is_mul = 1'b1;
          ciseu_pkg::ALU_SUB:  v = a - b;
          ciseu_pkg::ALU_DIV: begin
            if (b == '0) begin
              bad  = 1'b1;
              code = ciseu_pkg::FLT_DIV0;
            end
            dec.is_div = 1'b1;
            dec.wd     = 1'b0;
            dec.wp     = 1'b1;
          end
          ciseu_pkg::ALU_OR:   v = a | b;
          ciseu_pkg::ALU_XOR:  v = a ^ b;
          ciseu_pkg::ALU_NOR:  v = ~(a | b);
          ciseu_pkg::ALU_AND:  v = a & b;
          ciseu_pkg::ALU_NAND: v = ~(a & b);
          ciseu_pkg::ALU_NOT:  v = ~a;
          ciseu_pkg::ALU_CMP:  dec.wd = 1'b0;
          ciseu_pkg::ALU_INC:  v = a + W'(1);
          ciseu_pkg::ALU_DEC:  v = a - W'(1);
          ciseu_pkg::ALU_SHL:
            v = (64'(b) >= 64'(W)) ? '0 : (a << b[SW-1:0]);
          ciseu_pkg::ALU_SHR:
            v = (64'(b) >= 64'(W)) ? '0 : (a >> b[SW-1:0]);
          default: begin
            bad  = 1'b1;
            code = ciseu_pkg::FLT_INVAL;
          end
        endcase
        dec.res = 64'(v);
      end
      ciseu_pkg::GRP_CTL: begin
        unique case (sel)
          ciseu_pkg::CTL_RET:  dec.stk = ciseu_pkg::STK_POP_IP;
          ciseu_pkg::CTL_CALL: begin
            dec.stk  = ciseu_pkg::STK_PUSH;
            dec.sval = fallthrough_ip;
            take     = 1'b1;
          end
          ciseu_pkg::CTL_JMP:  take = 1'b1;
          ciseu_pkg::CTL_JC:   take = c;
          ciseu_pkg::CTL_JNC:  take = !c;
          ciseu_pkg::CTL_JZ:   take = z;
          ciseu_pkg::CTL_JNZ:  take = !z;
          ciseu_pkg::CTL_JL:   take = lt;
          ciseu_pkg::CTL_JLE:  take = lt || z;
          ciseu_pkg::CTL_JNL:  take = !lt;
          ciseu_pkg::CTL_JNLE: take = !lt && !z;
          ciseu_pkg::CTL_JG:   take = !lt && !z;
          ciseu_pkg::CTL_JGE:  take = !lt;
          ciseu_pkg::CTL_JNG:  take = z || lt;
          ciseu_pkg::CTL_JNGE: take = lt;
          default: begin
            bad  = 1'b1;
            code = ciseu_pkg::FLT_INVAL;
          end
        endcase
      end
      ciseu_pkg::GRP_SYS: begin
        unique case (sel)
          ciseu_pkg::SYS_MOV: begin
            dec.res = 64'(b);
            dec.wd  = 1'b1;
          end
          ciseu_pkg::SYS_NOP:   dec.sys = ciseu_pkg::ACT_NONE;
          ciseu_pkg::SYS_HLT:   dec.sys = ciseu_pkg::ACT_HALT;
          ciseu_pkg::SYS_PUSH: begin
            dec.stk  = ciseu_pkg::STK_PUSH;
            dec.sval = source_value;
          end
          ciseu_pkg::SYS_POP:   dec.stk = ciseu_pkg::STK_POP;
          ciseu_pkg::SYS_PUSHA: dec.sys = ciseu_pkg::ACT_PUSHA;
          ciseu_pkg::SYS_POPA:  dec.sys = ciseu_pkg::ACT_POPA;
          ciseu_pkg::SYS_INT: begin
            dec.sys = ciseu_pkg::ACT_INT;
            dec.res = dest_value;
          end
          ciseu_pkg::SYS_LIDT: begin
            dec.sys = ciseu_pkg::ACT_LIDT;
            dec.res = dest_value;
          end
          ciseu_pkg::SYS_IRET:  dec.sys = ciseu_pkg::ACT_IRET;
          ciseu_pkg::SYS_SCALL: dec.sys = ciseu_pkg::ACT_LEAVE;
          ciseu_pkg::SYS_SRET:  dec.sys = ciseu_pkg::ACT_SRET;
          ciseu_pkg::SYS_EUSER: begin
            dec.sys = ciseu_pkg::ACT_ENTER;
            dec.res = dest_value;
          end
          default: begin
            bad  = 1'b1;
            code = ciseu_pkg::FLT_INVAL;
          end
        endcase
        // privilege checks
        if (sel == ciseu_pkg::SYS_SCALL) begin
          if (protected_mode && !user_mode) begin
            bad  = 1'b1;
            code = ciseu_pkg::FLT_SUPV;
          end
        end else if (user_bad && (sel == ciseu_pkg::SYS_INT ||
                     sel == ciseu_pkg::SYS_LIDT || sel == ciseu_pkg::SYS_IRET ||
                     sel == ciseu_pkg::SYS_SRET || sel == ciseu_pkg::SYS_EUSER)) begin
          bad  = 1'b1;
          code = ciseu_pkg::FLT_USER;
        end
      end
      default: begin
        bad  = 1'b1;
        code = ciseu_pkg::FLT_INVAL;
      end
    endcase
    if (take) begin
      dec.br      = 1'b1;
      dec.next_ip = dest_value;
    end
    if (bad) begin
      dec         = '0;
      dec.next_ip = fallthrough_ip;
      dec.flt     = code;
    end
  end

  // ---------------- pipeline ----------------
  logic             valid [LAT];
  ciseu_pkg::ctrl_t ctrl  [LAT];
  logic [W:0]       rem   [LAT];
  logic [W-1:0]     quo   [LAT];
  logic [W-1:0]     dvs   [LAT];

  // multiplier partial products, stage 0
  logic [2*LW-1:0]  p_ll;
  logic [HW-1:0]    p_lh, p_hl;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= start;
    end
    ctrl[0] <= dec;
    rem[0]  <= '0;
    quo[0]  <= a;
    dvs[0]  <= b;
    p_ll    <= (2*LW)'(a[LW-1:0]) * (2*LW)'(b[LW-1:0]);
    p_lh    <= HW'(a[LW-1:0] * LW'(b[W-1:LW]));
    p_hl    <= HW'(LW'(a[W-1:LW]) * b[LW-1:0]);
  end

  logic [W-1:0] mul_sum;
  assign mul_sum = W'(p_ll) + {HW'(p_lh + p_hl), {LW{1'b0}}};

  for (genvar s = 1; s < LAT; s++) begin : g_div
    logic [W:0]       shifted;
    logic             fits;
    ciseu_pkg::ctrl_t ctrl_next;
    assign shifted = {rem[s-1][W-1:0], quo[s-1][W-1]};
    assign fits    = shifted >= {1'b0, dvs[s-1]};

    // product lands in the control record on its way out of stage 0
    always_comb begin
      ctrl_next = ctrl[s-1];
      if (s == 1 && ctrl[0].is_mul) begin
        ctrl_next.res = 64'(mul_sum);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else begin
        valid[s] <= valid[s-1];
      end
      ctrl[s] <= ctrl_next;
      rem[s] <= fits ? (shifted - {1'b0, dvs[s-1]}) : shifted;
      quo[s] <= {quo[s-1][W-2:0], fits};
      dvs[s] <= dvs[s-1];
    end
  end

  ciseu_pkg::ctrl_t last;
  assign last = ctrl[LAT-1];

  assign result_valid    = valid[LAT-1];
  assign result_value    = last.is_div ? 64'(quo[LAT-1]) : last.res;
  assign remainder_value = last.is_div ? 64'(rem[LAT-1][W-1:0]) : '0;
  assign writes_dest     = last.wd;
  assign writes_pair     = last.wp;
  assign branch_taken    = last.br;
  assign next_ip         = last.next_ip;
  assign stack_action    = last.stk;
  assign stack_value     = last.sval;
  assign system_action   = last.sys;
  assign fault_code      = last.flt;

`ifndef SYNTH
  a_lat : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, LAT))
    else $error("result without a matching start");

  a_fault_quiet : assert property (@(posedge clk) disable iff (rst)
    (result_valid && fault_code != ciseu_pkg::FLT_NONE) |->
      (!writes_dest && !writes_pair && !branch_taken &&
       stack_action == ciseu_pkg::STK_NONE && system_action == ciseu_pkg::ACT_NONE))
    else $error("faulting instruction has side effects");

  a_pair_excl : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(writes_pair && writes_dest))
    else $error("divide writes both pair and destination");

  a_rem_small : assert property (@(posedge clk) disable iff (rst)
    (result_valid && writes_pair) |-> (rem[LAT-1][W-1:0] < dvs[LAT-1]))
    else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire
